[rtl/obt_pkg.sv]
// ----------------------------------------------------------------------------
// obt_pkg: shared types and constants of the offset bitmap table
// Word count, derived widths, command codes, register indexes and the
// request bundle that drives the word store.
// ----------------------------------------------------------------------------
package obt_pkg;

	// storage geometry
	localparam int NUM_WORDS = 8;
	localparam int WORD_W    = 32;
	localparam int CAP_BITS  = NUM_WORDS * WORD_W;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OFF_W     = WIDX_W + 5;

	// numbers are 16-bit signed; bounds math needs room for min + capacity
	localparam int NUM_W = 16;
	localparam int BND_W = 18;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_NUMBER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NUMBER = 1'd1;

	// command codes
	typedef enum logic [2:0] {
		KIND_GET       = 3'd0,
		KIND_SET_BIT   = 3'd1,
		KIND_SET_RANGE = 3'd2,
		KIND_EXTRACT   = 3'd3,
		KIND_CLEAR     = 3'd4,
		KIND_IS_EMPTY  = 3'd5
	} kind_t;

	typedef logic signed [BND_W-1:0] bound_t;

	// request from the sequencer to the word store
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic              clr;
		logic [WIDX_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} store_req_t;

	// sign-extend a 16-bit number into the bounds width
	function automatic bound_t ext_num(input logic [NUM_W-1:0] v);
		return bound_t'({{(BND_W-NUM_W){v[NUM_W-1]}}, v});
	endfunction

endpackage

[rtl/obt_intf.sv]
// ----------------------------------------------------------------------------
// obt_intf: command and result channels of the offset bitmap table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface obt_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic signed [15:0] first_number;
	logic signed [15:0] last_number;
	logic              bit_value;

	modport source (output valid, kind, first_number, last_number, bit_value,
		input ready);
	modport sink (input valid, kind, first_number, last_number, bit_value,
		output ready);
endinterface

interface obt_rsp_if;
	logic        valid;
	logic        ready;
	logic        flag;
	logic [31:0] packed_bits;

	modport source (output valid, flag, packed_bits, input ready);
	modport sink (input valid, flag, packed_bits, output ready);
endinterface

[rtl/offset_bitmap_table.sv]
// ----------------------------------------------------------------------------
// offset_bitmap_table: bit map over a signed number range in 32-bit words
// Get, set bit, set range, extract, clear all and is-empty commands on a
// word memory, with min/max bounds set through the configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per beat; rsp returns exactly one result beat per
//   command, in order. min_number / max_number are written through cfg_we,
//   cfg_idx, cfg_wdata; the user must write them only while no command is in flight, the block does not enforce this.
//   One command is worked at a time; cmd.ready is high only when the
//   sequencer is idle. Each command passes two prep states, then:
//     get and set bit in range read and modify one word
//     set range reads and modifies each word touched
//     extract reads one or two words
//     clear all clears the valid bits and reads no word
//     is empty reads every word of the map
//     any command out of range or with an empty range reads no word
//   All words go through the single memory port: each word takes a read
//   state and a modify/write state.
//   Reset clears the valid bits of all words (the map reads as empty at
//   once) and loads min_number 0, max_number 255.
//   A result held by a stalled receiver sits in the output register; the
//   next command is still taken and waits in its final state for the slot.
// ----------------------------------------------------------------------------
module offset_bitmap_table (
	input  logic                                clk,
	input  logic                                arst_n,
	obt_cmd_if.sink                             cmd,
	obt_rsp_if.source                           rsp,
	input  logic                                cfg_we,
	input  logic [obt_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [obt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE1 = 6'b000010,
		ST_PRE2 = 6'b000100,
		ST_RD   = 6'b001000,
		ST_MOD  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam logic [obt_pkg::WORD_W-1:0] ONES  = '1;
	localparam logic [obt_pkg::WORD_W-1:0] ZEROS = '0;

	state_t                         state_q;
	obt_pkg::kind_t                 kind_q;
	logic [obt_pkg::NUM_W-1:0]      first_q;
	logic [obt_pkg::NUM_W-1:0]      last_q;
	logic                           val_q;
	logic [obt_pkg::NUM_W-1:0]      min_q;
	logic [obt_pkg::NUM_W-1:0]      max_q;
	obt_pkg::bound_t                lo_q;
	obt_pkg::bound_t                hi_q;
	obt_pkg::bound_t                a_q;
	obt_pkg::bound_t                b_q;
	logic                           flag_q;
	logic                           go_q;
	logic [obt_pkg::OFF_W-1:0]      o0_q;
	logic [obt_pkg::OFF_W-1:0]      o1_q;
	logic [obt_pkg::WIDX_W-1:0]     w0_q;
	logic [obt_pkg::WIDX_W-1:0]     widx_q;
	logic [obt_pkg::WIDX_W-1:0]     wend_q;
	logic [4:0]                     cnt_q;
	logic [obt_pkg::WORD_W-1:0]     acc_q;
	logic [obt_pkg::WORD_W-1:0]     packed_q;
	logic                           out_valid_q;
	logic                           out_flag_q;
	logic [obt_pkg::WORD_W-1:0]     out_packed_q;

	obt_pkg::store_req_t            req;
	logic [obt_pkg::WORD_W-1:0]     rd_word;

	obt_pkg::bound_t                f_num;
	obt_pkg::bound_t                l_num;
	obt_pkg::bound_t                cap_hi;
	obt_pkg::bound_t                max_num;
	obt_pkg::bound_t                l_clamp;
	logic                           f_in;
	logic                           range_empty;
	obt_pkg::bound_t                a_plus;
	obt_pkg::bound_t                bb;
	obt_pkg::bound_t                off0;
	obt_pkg::bound_t                off1;
	obt_pkg::bound_t                span;
	logic                           first_word;
	logic                           last_word;
	logic [4:0]                     lob;
	logic [4:0]                     hib;
	logic [obt_pkg::WORD_W-1:0]     wmask;
	logic [obt_pkg::WORD_W-1:0]     wdata;
	logic [2*obt_pkg::WORD_W-1:0]   ext_pair;
	logic [obt_pkg::WORD_W-1:0]     ext_bits;
	logic                           out_free;
	logic                           cmd_beat;

	assign cmd_beat  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.flag        = out_flag_q;
	assign rsp.packed_bits = out_packed_q;

	// configuration registers and registered bounds; both bounds are registered
	// from the configuration registers, the high bound clamped to the map capacity
	assign max_num = obt_pkg::ext_num(max_q);
	assign cap_hi  = obt_pkg::ext_num(min_q) + obt_pkg::bound_t'(obt_pkg::CAP_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= obt_pkg::NUM_W'(255);
			lo_q  <= '0;
			hi_q  <= obt_pkg::bound_t'(255);
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					obt_pkg::REG_MIN_NUMBER: min_q <= cfg_wdata;
					obt_pkg::REG_MAX_NUMBER: max_q <= cfg_wdata;
					default: ;
				endcase
			end
			lo_q <= obt_pkg::ext_num(min_q);
			hi_q <= (max_num > cap_hi) ? cap_hi : max_num;
		end
	end

	// first prep stage: range checks and clamps
	assign f_num       = obt_pkg::ext_num(first_q);
	assign l_num       = obt_pkg::ext_num(last_q);
	assign f_in        = (f_num >= lo_q) && (f_num <= hi_q);
	assign range_empty = f_num > l_num;
	assign l_clamp     = (l_num > hi_q) ? hi_q : l_num;

	// second prep stage: offsets into the map
	assign a_plus = a_q + obt_pkg::bound_t'(31);
	assign bb     = (kind_q == obt_pkg::KIND_EXTRACT && a_plus < b_q) ? a_plus : b_q;
	assign off0   = a_q - lo_q;
	assign off1   = bb - lo_q;
	assign span   = bb - a_q;

	// word modify: mask of the bits this word covers
	assign first_word = (widx_q == w0_q);
	assign last_word  = (widx_q == wend_q);
	assign lob        = first_word ? o0_q[4:0] : 5'd0;
	assign hib        = last_word ? o1_q[4:0] : 5'd31;
	assign wmask      = (ONES << lob) & (ONES >> (5'd31 - hib));
	assign wdata      = val_q ? (rd_word | wmask) : (rd_word & ~wmask);

	// extract: window of up to 32 bits over one or two words
	assign ext_pair = {(first_word ? ZEROS : rd_word), (first_word ? rd_word : acc_q)}
		>> o0_q[4:0];
	assign ext_bits = ext_pair[obt_pkg::WORD_W-1:0] & (ONES >> (5'd31 - cnt_q));

	// store requests
	always_comb begin
		req       = '0;
		req.addr  = widx_q;
		req.wdata = wdata;
		req.rd_en = (state_q == ST_RD);
		req.wr_en = (state_q == ST_MOD) &&
			(kind_q == obt_pkg::KIND_SET_BIT || kind_q == obt_pkg::KIND_SET_RANGE);
		req.clr   = (state_q == ST_PRE2) && (kind_q == obt_pkg::KIND_CLEAR);
	end

	obt_word_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_word (rd_word)
	);

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_beat) begin
						state_q <= ST_PRE1;
					end
				end
				ST_PRE1: state_q <= ST_PRE2;
				ST_PRE2: begin
					case (kind_q)
						obt_pkg::KIND_CLEAR:    state_q <= ST_DONE;
						obt_pkg::KIND_IS_EMPTY: state_q <= ST_RD;
						obt_pkg::KIND_EXTRACT:  state_q <= (a_q <= b_q) ? ST_RD : ST_DONE;
						default:                state_q <= go_q ? ST_RD : ST_DONE;
					endcase
				end
				ST_RD: state_q <= ST_MOD;
				ST_MOD: begin
					if (kind_q == obt_pkg::KIND_GET || last_word) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register valid: loaded from the final state, dropped on a beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_beat) begin
					kind_q  <= obt_pkg::kind_t'(cmd.kind);
					first_q <= cmd.first_number;
					last_q  <= cmd.last_number;
					val_q   <= cmd.bit_value;
				end
			end
			ST_PRE1: begin
				packed_q <= '0;
				acc_q    <= '0;
				// extract raises its start to the low bound
				a_q      <= (kind_q == obt_pkg::KIND_EXTRACT && f_num < lo_q) ? lo_q : f_num;
				b_q      <= (kind_q inside {obt_pkg::KIND_SET_RANGE, obt_pkg::KIND_EXTRACT}) ?
					l_clamp : f_num;
				go_q     <= (kind_q == obt_pkg::KIND_SET_RANGE) ? (!range_empty && f_in) : f_in;
				case (kind_q)
					obt_pkg::KIND_SET_BIT:   flag_q <= f_in;
					obt_pkg::KIND_SET_RANGE:
						flag_q <= range_empty || ((f_num >= lo_q) && (l_num <= hi_q));
					obt_pkg::KIND_IS_EMPTY:  flag_q <= 1'b1;
					default:                 flag_q <= 1'b0;
				endcase
			end
			ST_PRE2: begin
				o0_q  <= off0[obt_pkg::OFF_W-1:0];
				o1_q  <= off1[obt_pkg::OFF_W-1:0];
				cnt_q <= span[4:0];
				if (kind_q == obt_pkg::KIND_IS_EMPTY) begin
					w0_q   <= '0;
					widx_q <= '0;
					wend_q <= obt_pkg::WIDX_W'(obt_pkg::NUM_WORDS - 1);
				end else begin
					w0_q   <= off0[obt_pkg::OFF_W-1:5];
					widx_q <= off0[obt_pkg::OFF_W-1:5];
					wend_q <= off1[obt_pkg::OFF_W-1:5];
				end
			end
			ST_MOD: begin
				if (!last_word) begin
					widx_q <= widx_q + 1'b1;
				end
				case (kind_q)
					obt_pkg::KIND_GET: flag_q <= rd_word[o0_q[4:0]];
					obt_pkg::KIND_EXTRACT: begin
						acc_q <= rd_word;
						if (last_word) begin
							packed_q <= ext_bits;
						end
					end
					obt_pkg::KIND_IS_EMPTY: begin
						acc_q <= acc_q | rd_word;
						if (last_word) begin
							flag_q <= ((acc_q | rd_word) == '0);
						end
					end
					default: ;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					out_flag_q   <= flag_q;
					out_packed_q <= packed_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat |=> state_q == ST_PRE1)
		else $error("command beat did not start the sequencer");

	a_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> (state_q == ST_MOD) &&
			(kind_q == obt_pkg::KIND_SET_BIT || kind_q == obt_pkg::KIND_SET_RANGE))
		else $error("store write outside a set command");

	a_word_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> widx_q <= wend_q)
		else $error("word walk ran past its last word");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> rsp.valid && (state_q == ST_IDLE))
		else $error("finished result not loaded into output register");

endmodule

[rtl/obt_word_store.sv]
// ----------------------------------------------------------------------------
// obt_word_store: bitmap word memory with per-word valid bits
// One synchronous read port with registered read data and one write port.
// A word never written since reset or the last clear reads as zero.
// ----------------------------------------------------------------------------
module obt_word_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  obt_pkg::store_req_t             req,
	output logic [obt_pkg::WORD_W-1:0]      rd_word
);

	logic [obt_pkg::WORD_W-1:0]    mem [obt_pkg::NUM_WORDS];
	logic [obt_pkg::NUM_WORDS-1:0] vld_q;
	logic [obt_pkg::WORD_W-1:0]    rdata_s1;
	logic                          rvld_s1;

	// memory array: write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem[req.addr];
		end
	end

	// valid bits stand in for clearing the array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_s1 <= vld_q[req.addr];
			end
		end
	end

	assign rd_word = rvld_s1 ? rdata_s1 : '0;

endmodule
